[design/apc_pkg.sv]
`default_nettype none

package apc_pkg;

  localparam int CHAN_W          = 8;
  localparam int PROD_W          = 2 * CHAN_W;
  localparam int DIV_STAGES      = 4;
  localparam int STEPS_PER_STAGE = CHAN_W / DIV_STAGES;
  localparam int LANE_DEPTH      = DIV_STAGES + 1;
  localparam int OUT_LATENCY     = LANE_DEPTH + 1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  localparam logic MODE_PREMUL   = 1'b0;
  localparam logic MODE_UNPREMUL = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } in_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } out_pixel_t;

endpackage

`default_nettype wire

[design/apc_lane.sv]
`default_nettype none

module apc_lane
  import apc_pkg::*;
(
  input  logic              clk,
  input  logic              mode,
  input  logic [CHAN_W-1:0] chan,
  input  logic [CHAN_W-1:0] alpha,
  output logic [CHAN_W-1:0] chan_out
);

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [CHAN_W-1:0] quo;
    logic [CHAN_W-1:0] dvs;
    logic [CHAN_W-1:0] fixed;
    logic              use_div;
  } div_stage_t;

  // floor(x / 255) for x up to 255 * 255, i.e. any product of two 8-bit values
  function automatic logic [CHAN_W-1:0] div_chan_max(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + (PROD_W+1)'(x[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
    return t[PROD_W-1:CHAN_W];
  endfunction

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [CHAN_W-1:0] chan_a_r;
  logic [CHAN_W-1:0] alpha_a_r;
  logic              mode_a_r;
  logic [CHAN_W-1:0] factor;

  div_stage_t head;
  div_stage_t stage_r   [DIV_STAGES];
  div_stage_t stage_nxt [DIV_STAGES];

  assign factor   = (mode == MODE_UNPREMUL) ? CHAN_MAX : alpha;
  assign prod_nxt = PROD_W'(chan) * PROD_W'(factor);

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    chan_a_r  <= chan;
    alpha_a_r <= alpha;
    mode_a_r  <= mode;
  end

  always_comb begin
    head.rem     = prod_r;
    head.quo     = '0;
    head.dvs     = alpha_a_r;
    head.use_div = (mode_a_r == MODE_UNPREMUL) && (alpha_a_r != '0) && (chan_a_r < alpha_a_r);
    if (mode_a_r == MODE_PREMUL) begin
      head.fixed = div_chan_max(prod_r);
    end else if (alpha_a_r == '0) begin
      head.fixed = chan_a_r;
    end else begin
      head.fixed = CHAN_MAX;
    end
  end

  // restoring divide, quotient bits from the top down
  always_comb begin
    logic [PROD_W-1:0] trial;
    for (int s = 0; s < DIV_STAGES; s++) begin
      stage_nxt[s] = (s == 0) ? head : stage_r[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        trial = PROD_W'(stage_nxt[s].dvs) << (CHAN_W - 1 - s * STEPS_PER_STAGE - k);
        if (stage_nxt[s].rem >= trial) begin
          stage_nxt[s].rem = stage_nxt[s].rem - trial;
          stage_nxt[s].quo = stage_nxt[s].quo
                             | (CHAN_W'(1) << (CHAN_W - 1 - s * STEPS_PER_STAGE - k));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      stage_r[s] <= stage_nxt[s];
    end
  end

  assign chan_out = stage_r[DIV_STAGES-1].use_div ? stage_r[DIV_STAGES-1].quo
                                                  : stage_r[DIV_STAGES-1].fixed;

endmodule

`default_nettype wire

[design/alpha_premultiply_convert_core.sv]
// Converts one RGBA8 pixel per clock between straight and premultiplied alpha.
// busy stays low, so an item is taken on every cycle that start is high. Each
// result shows on out_pixel with out_valid for one cycle, once its item has
// passed the per-channel pipeline: one multiply stage, four radix-4 restoring
// divide stages, and the output register. Results leave in the order items
// arrive and cannot be held off. Write the mode register (0 premultiply, 1
// unpremultiply) only while no item is in flight.
`default_nettype none

module alpha_premultiply_convert_core
  import apc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_pixel_t  in_pixel,
  output logic       out_valid,
  output out_pixel_t out_pixel,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic                  mode_r;
  logic                  accept;
  logic [LANE_DEPTH-1:0] valid_r;
  logic [CHAN_W-1:0]     alpha_dly_r [LANE_DEPTH];
  logic [CHAN_W-1:0]     red_res;
  logic [CHAN_W-1:0]     green_res;
  logic [CHAN_W-1:0]     blue_res;
  logic                  out_valid_r;
  out_pixel_t            out_pixel_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PREMUL;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  apc_lane u_lane_red (
    .clk      (clk),
    .mode     (mode_r),
    .chan     (in_pixel.red),
    .alpha    (in_pixel.alpha),
    .chan_out (red_res)
  );

  apc_lane u_lane_green (
    .clk      (clk),
    .mode     (mode_r),
    .chan     (in_pixel.green),
    .alpha    (in_pixel.alpha),
    .chan_out (green_res)
  );

  apc_lane u_lane_blue (
    .clk      (clk),
    .mode     (mode_r),
    .chan     (in_pixel.blue),
    .alpha    (in_pixel.alpha),
    .chan_out (blue_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= {valid_r[LANE_DEPTH-2:0], accept};
      out_valid_r <= valid_r[LANE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    alpha_dly_r[0] <= in_pixel.alpha;
    for (int i = 1; i < LANE_DEPTH; i++) begin
      alpha_dly_r[i] <= alpha_dly_r[i-1];
    end
    out_pixel_r.red_out   <= red_res;
    out_pixel_r.green_out <= green_res;
    out_pixel_r.blue_out  <= blue_res;
    out_pixel_r.alpha_out <= alpha_dly_r[LANE_DEPTH-1];
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

`default_nettype wire

[design/apc_checker.sv]
`default_nettype none

module apc_checker
  import apc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input in_pixel_t  in_pixel,
  input logic       out_valid,
  input out_pixel_t out_pixel
);

  a_item_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##OUT_LATENCY out_valid)
    else $error("item taken but no result after pipeline latency");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!start || busy) |-> ##OUT_LATENCY !out_valid)
    else $error("result without a matching item");

  a_alpha_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |->
      ##OUT_LATENCY (out_pixel.alpha_out == $past(in_pixel.alpha, OUT_LATENCY)))
    else $error("alpha changed on its way through");

  a_opaque_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_pixel.alpha == CHAN_MAX)) |->
      ##OUT_LATENCY ((out_pixel.red_out == $past(in_pixel.red, OUT_LATENCY)) &&
                     (out_pixel.green_out == $past(in_pixel.green, OUT_LATENCY)) &&
                     (out_pixel.blue_out == $past(in_pixel.blue, OUT_LATENCY))))
    else $error("opaque pixel colors changed");

endmodule

bind alpha_premultiply_convert_core apc_checker u_apc_checker (.*);

`default_nettype wire

[dv/alpha_premultiply_convert_checker.sv]
`default_nettype none

module alpha_premultiply_convert_checker
  import apc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_pixel_t  in_pixel,
  input  logic       out_valid,
  input  out_pixel_t out_pixel,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output int         mismatch_count,
  output int         pending_pixels
);
  timeunit 1ns;
  timeprecision 1ps;

  logic       mode_now;
  out_pixel_t expected_pixels[$];

  function automatic logic [CHAN_W-1:0] convert_chan(logic [CHAN_W-1:0] c,
                                                     logic [CHAN_W-1:0] a,
                                                     logic md);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    if (md == MODE_PREMUL) begin
      prod = {{CHAN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, a};
      quot = prod / {{CHAN_W{1'b0}}, CHAN_MAX};
      return quot[CHAN_W-1:0];
    end
    if (a == '0) begin
      return c;
    end
    prod = {{CHAN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, CHAN_MAX};
    quot = prod / {{CHAN_W{1'b0}}, a};
    if (quot > {{CHAN_W{1'b0}}, CHAN_MAX}) begin
      return CHAN_MAX;
    end
    return quot[CHAN_W-1:0];
  endfunction

  function automatic out_pixel_t convert_pixel(in_pixel_t px, logic md);
    out_pixel_t res;
    res.red_out   = convert_chan(px.red, px.alpha, md);
    res.green_out = convert_chan(px.green, px.alpha, md);
    res.blue_out  = convert_chan(px.blue, px.alpha, md);
    res.alpha_out = px.alpha;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got);
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count = 0;
    pending_pixels = 0;
  end

  always @(posedge clk) begin
    out_pixel_t want;
    if (!rst_n) begin
      mode_now <= MODE_PREMUL;
      expected_pixels.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no item pending", 8'd0, out_pixel.alpha_out);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel.red_out !== want.red_out)
            report_mismatch("red_out", want.red_out, out_pixel.red_out);
          if (out_pixel.green_out !== want.green_out)
            report_mismatch("green_out", want.green_out, out_pixel.green_out);
          if (out_pixel.blue_out !== want.blue_out)
            report_mismatch("blue_out", want.blue_out, out_pixel.blue_out);
          if (out_pixel.alpha_out !== want.alpha_out)
            report_mismatch("alpha_out", want.alpha_out, out_pixel.alpha_out);
        end
      end
      if (start && !busy) begin
        expected_pixels.push_back(convert_pixel(in_pixel, mode_now));
      end
      if (cfg_we) begin
        mode_now <= cfg_wdata;
      end
    end
    pending_pixels = expected_pixels.size();
  end

endmodule

`default_nettype wire

[dv/tb_alpha_premultiply_convert_core.sv]
`default_nettype none

module tb_alpha_premultiply_convert_core;
  import apc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_PIXELS = 230;
  localparam int NUM_PHASES   = 8;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_pixel_t  in_pixel;
  logic       out_valid;
  out_pixel_t out_pixel;
  logic       cfg_we;
  logic       cfg_wdata;
  int         mismatch_count;
  int         pending_pixels;
  int         cycle_count;
  int         idle_pct;

  alpha_premultiply_convert_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  alpha_premultiply_convert_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_pixel      (out_pixel),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_pixels (pending_pixels)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("alpha_premultiply_convert_core verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk); while (pending_pixels != 0);
  endtask

  task automatic write_mode(input logic md);
    start <= 1'b0;
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= md;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_pixel(input in_pixel_t px);
    logic taken;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_pixel <= px;
    start    <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic [CHAN_W-1:0] pick_alpha();
    case ($urandom_range(9))
      0: return '0;
      1: return CHAN_MAX;
      2: return 8'd1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic in_pixel_t make_pixel(logic md);
    in_pixel_t px;
    px.alpha = pick_alpha();
    if (md == MODE_UNPREMUL && $urandom_range(9) < 8) begin
      // premultiplied content: colors never exceed alpha
      px.red   = CHAN_W'($urandom_range(px.alpha));
      px.green = CHAN_W'($urandom_range(px.alpha));
      px.blue  = CHAN_W'($urandom_range(px.alpha));
    end else begin
      px.red   = CHAN_W'($urandom_range(255));
      px.green = CHAN_W'($urandom_range(255));
      px.blue  = CHAN_W'($urandom_range(255));
      if ($urandom_range(9) == 0) px.red = CHAN_MAX;
      if ($urandom_range(9) == 0) px.blue = '0;
    end
    return px;
  endfunction

  initial begin
    logic phase_mode;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_pixel  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    idle_pct  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_PREMUL);
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd0, 8'd128, 8'd0});
    send_pixel('{8'd255, 8'd128, 8'd1, 8'd255});
    send_pixel('{8'd255, 8'd254, 8'd1, 8'd1});
    send_pixel('{8'd200, 8'd17, 8'd99, 8'd128});
    send_pixel('{8'd0, 8'd255, 8'd170, 8'd254});
    send_pixel('{8'd85, 8'd170, 8'd51, 8'd3});

    write_mode(MODE_UNPREMUL);
    send_pixel('{8'd200, 8'd17, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd200, 8'd100, 8'd50, 8'd100});
    send_pixel('{8'd100, 8'd100, 8'd99, 8'd100});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd255});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'd1, 8'd0, 8'd255, 8'd1});
    send_pixel('{8'd1, 8'd2, 8'd3, 8'd255});
    send_pixel('{8'd127, 8'd64, 8'd128, 8'd128});
    send_pixel('{8'd253, 8'd254, 8'd255, 8'd254});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin phase_mode = MODE_PREMUL;   idle_pct = 30; end
        1: begin phase_mode = MODE_UNPREMUL; idle_pct = 0;  end
        2: begin phase_mode = MODE_UNPREMUL; idle_pct = 60; end
        3: begin phase_mode = MODE_PREMUL;   idle_pct = 10; end
        4: begin phase_mode = MODE_UNPREMUL; idle_pct = 45; end
        5: begin phase_mode = MODE_PREMUL;   idle_pct = 20; end
        6: begin phase_mode = MODE_UNPREMUL; idle_pct = 80; end
        default: begin phase_mode = MODE_PREMUL; idle_pct = 0; end
      endcase
      write_mode(phase_mode);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (ph == 2 && i == PHASE_PIXELS / 2) begin
          start <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        send_pixel(make_pixel(phase_mode));
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (OUT_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("alpha_premultiply_convert_core verification clean");
    end else begin
      $display("alpha_premultiply_convert_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/apc_pkg.sv
design/apc_lane.sv
design/alpha_premultiply_convert_core.sv
design/apc_checker.sv
dv/alpha_premultiply_convert_checker.sv
dv/tb_alpha_premultiply_convert_core.sv
